// File: src/fac_pkg.sv
`default_nettype none
// Shared constants, command codes, control structs and helpers of the frustum box culler.
package fac_pkg;

    // Default fixed-point format and coordinate range.
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    // Field widths.
    localparam int ENTRY_W  = 32;
    localparam int PLANE_W  = ENTRY_W + 1;
    localparam int MARGIN_W = 24;

    // Corners enter the multiplier in slices of this many bits.
    localparam int CHUNK_W     = 24;
    localparam int CHUNK_IDX_W = 2;

    // Item commands.
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_BOX   = 2'd1;
    localparam logic [1:0] CMD_VOXEL = 2'd2;

    // Register indexes on the configuration port.
    localparam logic REG_CULL_ENABLE = 1'b0;
    localparam logic REG_BOX_MARGIN  = 1'b1;

    // Register reset values: culling on, margin 12.0.
    localparam logic                CULL_ENABLE_RST = 1'b1;
    localparam logic [MARGIN_W-1:0] BOX_MARGIN_RST  = 24'd786432;

    // Commands from the sequencer to the datapath.
    typedef struct packed {
        logic                   load_we;
        logic                   capture;
        logic                   capture_vox;
        logic                   vox_mul;
        logic                   corner;
        logic                   grow;
        logic [1:0]             axis;
        logic                   plane_rd;
        logic                   plane_init;
        logic [2:0]             plane;
        logic                   mac_step;
        logic [1:0]             comp;
        logic [CHUNK_IDX_W-1:0] chunk;
    } dp_cmd_t;

    // Status from the datapath to the sequencer.
    typedef struct packed {
        logic all_loaded;
        logic acc_neg;
    } dp_stat_t;

    // Saturates a sign-extended value to a signed range of the given bit count.
    function automatic logic signed [127:0] sat_wide(input logic signed [127:0] v,
                                                     input int bits);
        logic signed [127:0] hi;
        logic signed [127:0] lo;
        hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
        lo = -hi - 128'sd1;
        if (v > hi) begin
            sat_wide = hi;
        end
        else if (v < lo) begin
            sat_wide = lo;
        end
        else begin
            sat_wide = v;
        end
    endfunction

endpackage
`default_nettype wire

// File: src/fac_regs.sv
`default_nettype none
// Configuration registers of the frustum box culler behind an APB-style port.
module fac_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic                               cull_enable,
    output logic [fac_pkg::MARGIN_W-1:0]       box_margin
);

    logic                          cull_enable_reg;
    logic [fac_pkg::MARGIN_W-1:0]  box_margin_reg;
    logic                          wr_en;

    // The port never inserts wait states.
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes, decoded on the word address.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cull_enable_reg <= fac_pkg::CULL_ENABLE_RST;
            box_margin_reg  <= fac_pkg::BOX_MARGIN_RST;
        end
        else if (wr_en) begin
            case (paddr[2])
                fac_pkg::REG_CULL_ENABLE: cull_enable_reg <= pwdata[0];
                fac_pkg::REG_BOX_MARGIN:  box_margin_reg  <= pwdata[fac_pkg::MARGIN_W-1:0];
                default:                  cull_enable_reg <= cull_enable_reg;
            endcase
        end
    end

    // Read data.
    always_comb begin
        case (paddr[2])
            fac_pkg::REG_CULL_ENABLE: prdata = 32'(cull_enable_reg);
            fac_pkg::REG_BOX_MARGIN:  prdata = 32'(box_margin_reg);
            default:                  prdata = '0;
        endcase
    end

    assign cull_enable = cull_enable_reg;
    assign box_margin  = box_margin_reg;

endmodule
`default_nettype wire

// File: src/fac_ctrl.sv
`default_nettype none
// Sequencer of the frustum box culler: box setup, then one plane after another.
module fac_ctrl #(
    parameter int NCH = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         cmd,
    input  wire logic               cull_enable,
    input  wire fac_pkg::dp_stat_t  dp_stat,
    output fac_pkg::dp_cmd_t        dp_cmd,
    output logic                    busy,
    output logic                    done,
    output logic                    visible
);

    localparam logic [fac_pkg::CHUNK_IDX_W-1:0] LAST_CHUNK =
        fac_pkg::CHUNK_IDX_W'(NCH - 1);
    localparam logic [1:0] LAST_AXIS  = 2'd2;
    localparam logic [1:0] LAST_COMP  = 2'd2;
    localparam logic [2:0] LAST_PLANE = 3'd5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_VOX_MUL,
        S_CORNER,
        S_GROW,
        S_PLANE_RD,
        S_PLANE_INIT,
        S_MAC,
        S_DRAIN,
        S_CHECK
    } state_t;

    state_t                          state_reg;
    logic [1:0]                      axis_reg;
    logic [2:0]                      plane_reg;
    logic [1:0]                      comp_reg;
    logic [fac_pkg::CHUNK_IDX_W-1:0] chunk_reg;
    logic                            done_reg;
    logic                            visible_reg;
    logic                            accept;
    logic                            is_test;
    logic                            bypass;

    assign busy    = (state_reg != S_IDLE);
    assign accept  = start && (state_reg == S_IDLE);
    assign is_test = (cmd == fac_pkg::CMD_BOX) || (cmd == fac_pkg::CMD_VOXEL);
    assign bypass  = !cull_enable || !dp_stat.all_loaded;

    // State, counters and the result strobe.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg   <= S_IDLE;
            axis_reg    <= '0;
            plane_reg   <= '0;
            comp_reg    <= '0;
            chunk_reg   <= '0;
            done_reg    <= 1'b0;
            visible_reg <= 1'b0;
        end
        else begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (accept && is_test) begin
                        if (bypass) begin
                            done_reg    <= 1'b1;
                            visible_reg <= 1'b1;
                        end
                        else begin
                            axis_reg  <= '0;
                            state_reg <= S_VOX_MUL;
                        end
                    end
                end
                S_VOX_MUL: state_reg <= S_CORNER;
                S_CORNER:  state_reg <= S_GROW;
                S_GROW: begin
                    if (axis_reg == LAST_AXIS) begin
                        plane_reg <= '0;
                        state_reg <= S_PLANE_RD;
                    end
                    else begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_VOX_MUL;
                    end
                end
                S_PLANE_RD: state_reg <= S_PLANE_INIT;
                S_PLANE_INIT: begin
                    comp_reg  <= '0;
                    chunk_reg <= '0;
                    state_reg <= S_MAC;
                end
                S_MAC: begin
                    if (chunk_reg == LAST_CHUNK) begin
                        chunk_reg <= '0;
                        if (comp_reg == LAST_COMP) begin
                            state_reg <= S_DRAIN;
                        end
                        else begin
                            comp_reg <= comp_reg + 2'd1;
                        end
                    end
                    else begin
                        chunk_reg <= chunk_reg + 1'b1;
                    end
                end
                S_DRAIN: state_reg <= S_CHECK;
                S_CHECK: begin
                    // A plane with the box fully outside ends the test early.
                    if (dp_stat.acc_neg) begin
                        done_reg    <= 1'b1;
                        visible_reg <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                    else if (plane_reg == LAST_PLANE) begin
                        done_reg    <= 1'b1;
                        visible_reg <= 1'b1;
                        state_reg   <= S_IDLE;
                    end
                    else begin
                        plane_reg <= plane_reg + 3'd1;
                        state_reg <= S_PLANE_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Datapath commands decoded from the state.
    always_comb begin
        dp_cmd             = '0;
        dp_cmd.load_we     = accept && (cmd == fac_pkg::CMD_LOAD);
        dp_cmd.capture     = accept && is_test && !bypass;
        dp_cmd.capture_vox = (cmd == fac_pkg::CMD_VOXEL);
        dp_cmd.vox_mul     = (state_reg == S_VOX_MUL);
        dp_cmd.corner      = (state_reg == S_CORNER);
        dp_cmd.grow        = (state_reg == S_GROW);
        dp_cmd.axis        = axis_reg;
        dp_cmd.plane_rd    = (state_reg == S_PLANE_RD);
        dp_cmd.plane_init  = (state_reg == S_PLANE_INIT);
        dp_cmd.plane       = plane_reg;
        dp_cmd.mac_step    = (state_reg == S_MAC);
        dp_cmd.comp        = comp_reg;
        dp_cmd.chunk       = chunk_reg;
    end

    assign done    = done_reg;
    assign visible = visible_reg;

endmodule
`default_nettype wire

// File: src/fac_dp.sv
`default_nettype none
// Datapath of the frustum box culler: matrix rows, box corners and the plane accumulator.
module fac_dp #(
    parameter int FRAC_BITS   = fac_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = fac_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire fac_pkg::dp_cmd_t                    dp_cmd,
    input  wire logic [1:0]                          row_sel,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  entry_c0,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  entry_c1,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  entry_c2,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  entry_c3,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  min_x,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  min_y,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  min_z,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  max_x,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  max_y,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  max_z,
    input  wire logic [fac_pkg::MARGIN_W-1:0]        box_margin,
    output fac_pkg::dp_stat_t                        dp_stat
);

    localparam int ENTRY_W = fac_pkg::ENTRY_W;
    localparam int PLANE_W = fac_pkg::PLANE_W;
    localparam int CHUNK_W = fac_pkg::CHUNK_W;
    localparam int PT_W    = COORD_WIDTH + FRAC_BITS;
    localparam int NCH     = (PT_W + CHUNK_W - 1) / CHUNK_W;
    localparam int EXT_W   = NCH * CHUNK_W;
    localparam int MULB_W  = CHUNK_W + 1;
    localparam int PROD_W  = PLANE_W + MULB_W;
    localparam int ACC_W   = PLANE_W + EXT_W + 4;
    localparam int SH_W    = $clog2(EXT_W);
    localparam int VOX_W   = 2 * ENTRY_W;
    localparam int VTOP_W  = VOX_W + 1;
    localparam int GROW_W  = PT_W + 2;
    localparam logic [1:0] W_ROW = 2'd3;
    localparam logic [fac_pkg::CHUNK_IDX_W-1:0] LAST_CHUNK =
        fac_pkg::CHUNK_IDX_W'(NCH - 1);
    localparam logic signed [GROW_W-1:0] MARGIN_CAP = GROW_W'(128) <<< FRAC_BITS;

    // Matrix rows, one row per word; undefined until loaded.
    logic [3:0][ENTRY_W-1:0]  row_mem [4];
    logic [3:0][ENTRY_W-1:0]  row3_reg;
    logic [3:0][ENTRY_W-1:0]  rowr_reg;
    logic [3:0]               rows_loaded_reg;

    // Captured test item.
    logic signed [ENTRY_W-1:0] in_min_reg [3];
    logic signed [ENTRY_W-1:0] in_max_reg [3];
    logic                      is_vox_reg;

    // Box setup.
    logic signed [VOX_W-1:0]   vox_prod_reg;
    logic signed [VTOP_W-1:0]  vox_top;
    logic signed [127:0]       sat_vmin;
    logic signed [127:0]       sat_vmax;
    logic signed [127:0]       sat_bmin;
    logic signed [127:0]       sat_bmax;
    logic signed [PT_W-1:0]    raw_min_next;
    logic signed [PT_W-1:0]    raw_max_next;
    logic signed [PT_W-1:0]    raw_min_reg;
    logic signed [PT_W-1:0]    raw_max_reg;
    logic signed [GROW_W-1:0]  margin_ext;
    logic signed [GROW_W-1:0]  margin_use;
    logic signed [GROW_W-1:0]  grow_lo;
    logic signed [GROW_W-1:0]  grow_hi;
    logic signed [127:0]       sat_lo;
    logic signed [127:0]       sat_hi;
    logic signed [PT_W-1:0]    box_min_reg [3];
    logic signed [PT_W-1:0]    box_max_reg [3];

    // Plane evaluation.
    logic                      plus;
    logic signed [PLANE_W-1:0] plane_sum [4];
    logic signed [PLANE_W-1:0] n_reg [3];
    logic signed [PLANE_W-1:0] n_sel;
    logic signed [PT_W-1:0]    corner;
    logic signed [EXT_W-1:0]   corner_ext;
    logic [CHUNK_W-1:0]        chunk_bits;
    logic signed [MULB_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic [fac_pkg::CHUNK_IDX_W-1:0] chunk_d_reg;
    logic                      add_pend_reg;
    logic [SH_W-1:0]           add_shift;
    logic signed [ACC_W-1:0]   acc_reg;

    // Memory write on a load and two registered row reads per plane.
    always_ff @(posedge clk) begin
        if (dp_cmd.load_we) begin
            row_mem[row_sel] <= {entry_c3, entry_c2, entry_c1, entry_c0};
        end
        if (dp_cmd.plane_rd) begin
            row3_reg <= row_mem[W_ROW];
            rowr_reg <= row_mem[dp_cmd.plane[2:1]];
        end
    end

    // Control state: loaded rows and the pending accumulate.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rows_loaded_reg <= '0;
            add_pend_reg    <= 1'b0;
        end
        else begin
            if (dp_cmd.load_we) begin
                rows_loaded_reg <= rows_loaded_reg | (4'b0001 << row_sel);
            end
            add_pend_reg <= dp_cmd.mac_step;
        end
    end

    // Voxel section bounds, and world boxes clamped to the corner range.
    always_comb begin
        vox_top  = VTOP_W'(vox_prod_reg) + VTOP_W'(in_max_reg[0]);
        sat_vmin = fac_pkg::sat_wide(128'(vox_prod_reg), COORD_WIDTH);
        sat_vmax = fac_pkg::sat_wide(128'(vox_top), COORD_WIDTH);
        sat_bmin = fac_pkg::sat_wide(128'(in_min_reg[dp_cmd.axis]), PT_W);
        sat_bmax = fac_pkg::sat_wide(128'(in_max_reg[dp_cmd.axis]), PT_W);
        if (is_vox_reg) begin
            raw_min_next = {sat_vmin[COORD_WIDTH-1:0], {FRAC_BITS{1'b0}}};
            raw_max_next = {sat_vmax[COORD_WIDTH-1:0], {FRAC_BITS{1'b0}}};
        end
        else begin
            raw_min_next = sat_bmin[PT_W-1:0];
            raw_max_next = sat_bmax[PT_W-1:0];
        end
    end

    // Margin, capped at 128 units, grows the box and clamps at the range ends.
    always_comb begin
        margin_ext = GROW_W'(box_margin);
        margin_use = (margin_ext > MARGIN_CAP) ? MARGIN_CAP : margin_ext;
        grow_lo    = GROW_W'(raw_min_reg) - margin_use;
        grow_hi    = GROW_W'(raw_max_reg) + margin_use;
        sat_lo     = fac_pkg::sat_wide(128'(grow_lo), PT_W);
        sat_hi     = fac_pkg::sat_wide(128'(grow_hi), PT_W);
    end

    // Plane components: row 3 plus or minus the selected row.
    always_comb begin
        plus = ~dp_cmd.plane[0];
        for (int c = 0; c < 4; c++) begin
            plane_sum[c] = plus
                ? PLANE_W'($signed(row3_reg[c])) + PLANE_W'($signed(rowr_reg[c]))
                : PLANE_W'($signed(row3_reg[c])) - PLANE_W'($signed(rowr_reg[c]));
        end
    end

    // One slice of the positive-vertex corner times one normal component.
    always_comb begin
        n_sel      = n_reg[dp_cmd.comp];
        corner     = n_sel[PLANE_W-1] ? box_min_reg[dp_cmd.comp] : box_max_reg[dp_cmd.comp];
        corner_ext = EXT_W'(corner);
        chunk_bits = corner_ext[dp_cmd.chunk * CHUNK_W +: CHUNK_W];
        mul_b      = {(dp_cmd.chunk == LAST_CHUNK) & chunk_bits[CHUNK_W-1], chunk_bits};
        prod_next  = n_sel * mul_b;
        add_shift  = SH_W'(chunk_d_reg) * SH_W'(CHUNK_W);
    end

    // Item capture, box setup registers and the multiply-accumulate pipeline.
    always_ff @(posedge clk) begin
        if (dp_cmd.capture) begin
            in_min_reg[0] <= min_x;
            in_min_reg[1] <= min_y;
            in_min_reg[2] <= min_z;
            in_max_reg[0] <= max_x;
            in_max_reg[1] <= max_y;
            in_max_reg[2] <= max_z;
            is_vox_reg    <= dp_cmd.capture_vox;
        end
        if (dp_cmd.vox_mul) begin
            vox_prod_reg <= in_min_reg[dp_cmd.axis] * in_max_reg[0];
        end
        if (dp_cmd.corner) begin
            raw_min_reg <= raw_min_next;
            raw_max_reg <= raw_max_next;
        end
        if (dp_cmd.grow) begin
            box_min_reg[dp_cmd.axis] <= sat_lo[PT_W-1:0];
            box_max_reg[dp_cmd.axis] <= sat_hi[PT_W-1:0];
        end
        if (dp_cmd.plane_init) begin
            for (int i = 0; i < 3; i++) begin
                n_reg[i] <= plane_sum[i];
            end
        end
        prod_reg    <= prod_next;
        chunk_d_reg <= dp_cmd.chunk;
        if (dp_cmd.plane_init) begin
            acc_reg <= ACC_W'(plane_sum[3]) <<< FRAC_BITS;
        end
        else if (add_pend_reg) begin
            acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< add_shift);
        end
    end

    assign dp_stat.all_loaded = &rows_loaded_reg;
    assign dp_stat.acc_neg    = acc_reg[ACC_W-1];

endmodule
`default_nettype wire

// File: src/frustum_aabb_culler.sv
`default_nettype none
// Frustum culler for axis-aligned boxes. A load, an unknown command, or a test taken while
// culling is off or the matrix is incomplete leaves busy low; such a test shows done next cycle.
// A full test runs box setup (voxel multiply, corner, grow per axis), then per plane a row read,
// an init, the steps of the shared 33x25 multiply-accumulate unit (three components of NCH slices,
// NCH = ceil((COORD_WIDTH + FRAC_BITS) / 24)), a drain and a check; a rejecting plane ends early.
// done is a one-cycle strobe the receiver cannot stall; rst_n (async) clears config and control, not data.
module frustum_aabb_culler #(
    parameter int FRAC_BITS   = fac_pkg::FRAC_BITS_DEF,
    parameter int COORD_WIDTH = fac_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [2:0]                          paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          cmd,
    input  wire logic [1:0]                          row_sel,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  entry_c0,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  entry_c1,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  entry_c2,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  entry_c3,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  min_x,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  min_y,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  min_z,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  max_x,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  max_y,
    input  wire logic signed [fac_pkg::ENTRY_W-1:0]  max_z,
    output logic                                     done,
    output logic                                     visible
);

    localparam int PT_W = COORD_WIDTH + FRAC_BITS;
    localparam int NCH  = (PT_W + fac_pkg::CHUNK_W - 1) / fac_pkg::CHUNK_W;

    logic                          cull_enable;
    logic [fac_pkg::MARGIN_W-1:0]  box_margin;
    fac_pkg::dp_cmd_t              dp_cmd;
    fac_pkg::dp_stat_t             dp_stat;

    // Configuration registers.
    fac_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .cull_enable (cull_enable),
        .box_margin  (box_margin)
    );

    // Sequencer.
    fac_ctrl #(
        .NCH (NCH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .cull_enable (cull_enable),
        .dp_stat     (dp_stat),
        .dp_cmd      (dp_cmd),
        .busy        (busy),
        .done        (done),
        .visible     (visible)
    );

    // Datapath.
    fac_dp #(
        .FRAC_BITS   (FRAC_BITS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .dp_cmd     (dp_cmd),
        .row_sel    (row_sel),
        .entry_c0   (entry_c0),
        .entry_c1   (entry_c1),
        .entry_c2   (entry_c2),
        .entry_c3   (entry_c3),
        .min_x      (min_x),
        .min_y      (min_y),
        .min_z      (min_z),
        .max_x      (max_x),
        .max_y      (max_y),
        .max_z      (max_z),
        .box_margin (box_margin),
        .dp_stat    (dp_stat)
    );

endmodule
`default_nettype wire

// File: src/fac_checker.sv
`default_nettype none
// Port-level checks of the frustum box culler and their binding to the top level.
module fac_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic [1:0] cmd,
    input wire logic       done
);

    // A result follows either a test just taken or the end of a running test.
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result strobe without a test item");

    // A running test ends only by giving its result.
    a_busy_end: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("test ended without a result");

    // A matrix load gives no result.
    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (cmd == fac_pkg::CMD_LOAD)) |=> !done)
        else $error("result strobe after a load item");

    // A test item is either answered at once or starts a run.
    a_test_taken: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((cmd == fac_pkg::CMD_BOX) || (cmd == fac_pkg::CMD_VOXEL)))
        |=> (done || busy))
        else $error("test item dropped");

    // The result is shown only once the block is free again.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !(done && busy))
        else $error("result strobe while busy");

endmodule

bind frustum_aabb_culler fac_checker u_fac_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .done  (done)
);
`default_nettype wire
